// ===== sv/apt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apt_pkg
// Shared widths, constants and types for the accelerometer peak and tap latch.
// ----------------------------------------------------------------------------
package apt_pkg;

  localparam int unsigned LSB_PER_G = 8192;
  localparam int unsigned MG_PER_G  = 1000;
  localparam int unsigned LSB_SHIFT = $clog2(LSB_PER_G);

  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned SQ_W    = 32;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned SCALE_W = 20;
  localparam int unsigned RAD_W   = 52;
  localparam int unsigned ROOT_W  = RAD_W / 2;
  localparam int unsigned REM_W   = ROOT_W + 2;
  localparam int unsigned STEP_W  = $clog2(ROOT_W);
  localparam int unsigned PEAK_W  = 13;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned BYTE_W  = 8;

  localparam logic [SCALE_W-1:0] RAD_SCALE = SCALE_W'(MG_PER_G * MG_PER_G);
  localparam logic [ROOT_W-1:0]  REF_ROOT  = ROOT_W'(MG_PER_G * LSB_PER_G);
  localparam logic [PEAK_W-1:0]  PEAK_MAX  = '1;

  localparam logic [KIND_W-1:0] TAP_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] TAP_SINGLE = 2'd1;
  localparam logic [KIND_W-1:0] TAP_DOUBLE = 2'd2;
  localparam int unsigned STATUS_TAP_BIT = 1;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned PTR_W   = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W   = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic                     do_sample;
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
    logic [KIND_W-1:0]        tap_kind;
    logic                     peak_read;
    logic                     tap_poll;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

// ===== sv/accel_peak_and_tap_latch.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accel_peak_and_tap_latch
// A used sample passes through squaring, scaling, the 26-step square root
// and emit; a skipped sample goes straight to emit. A new request is taken
// only once the previous one has been emitted into the result register.
// Reset: asynchronous, active low; clears enable, peak, tap state and queues.
// ----------------------------------------------------------------------------
module accel_peak_and_tap_latch import apt_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_wdata_i,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic                     sample_ok_i,
  input  wire logic signed [AXIS_W-1:0] accel_x_i,
  input  wire logic signed [AXIS_W-1:0] accel_y_i,
  input  wire logic signed [AXIS_W-1:0] accel_z_i,
  input  wire logic                     status_ok_i,
  input  wire logic [BYTE_W-1:0]        status_byte_i,
  input  wire logic                     tap_status_ok_i,
  input  wire logic [BYTE_W-1:0]        tap_status_byte_i,
  input  wire logic                     peak_read_i,
  input  wire logic                     tap_poll_i,
  output logic                          empty,
  input  wire logic                     pop,
  output logic [PEAK_W-1:0]             peak_mg_o,
  output logic                          tap_valid_o,
  output logic [KIND_W-1:0]             tap_kind_o,
  output logic [SEQ_W-1:0]              tap_seq_o
);

  item_t     front_item;
  item_t     head_item;
  q_status_t q_status;
  logic      q_pop;

  apt_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .sample_ok_i       (sample_ok_i),
    .accel_x_i         (accel_x_i),
    .accel_y_i         (accel_y_i),
    .accel_z_i         (accel_z_i),
    .status_ok_i       (status_ok_i),
    .status_byte_i     (status_byte_i),
    .tap_status_ok_i   (tap_status_ok_i),
    .tap_status_byte_i (tap_status_byte_i),
    .peak_read_i       (peak_read_i),
    .tap_poll_i        (tap_poll_i),
    .item_o            (front_item)
  );

  apt_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (q_pop),
    .item_o   (head_item),
    .status_o (q_status)
  );

  apt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (head_item),
    .q_empty_i   (q_status.empty),
    .q_pop_o     (q_pop),
    .pop         (pop),
    .empty       (empty),
    .peak_mg_o   (peak_mg_o),
    .tap_valid_o (tap_valid_o),
    .tap_kind_o  (tap_kind_o),
    .tap_seq_o   (tap_seq_o)
  );

  assign full = q_status.full;

endmodule
`default_nettype wire

// ===== sv/apt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apt_front
// Holds the enable register and classifies each request: whether the sample
// is used and which tap kind, if any, it latches.
// ----------------------------------------------------------------------------
module apt_front import apt_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_wdata_i,
  input  wire logic                     sample_ok_i,
  input  wire logic signed [AXIS_W-1:0] accel_x_i,
  input  wire logic signed [AXIS_W-1:0] accel_y_i,
  input  wire logic signed [AXIS_W-1:0] accel_z_i,
  input  wire logic                     status_ok_i,
  input  wire logic [BYTE_W-1:0]        status_byte_i,
  input  wire logic                     tap_status_ok_i,
  input  wire logic [BYTE_W-1:0]        tap_status_byte_i,
  input  wire logic                     peak_read_i,
  input  wire logic                     tap_poll_i,
  output item_t                         item_o
);

  logic              enable_q;
  logic [KIND_W-1:0] tap_code;
  logic              kind_ok;
  logic              tap_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  assign tap_code = tap_status_byte_i[KIND_W-1:0];

  always_comb begin
    unique case (tap_code) inside
      TAP_SINGLE, TAP_DOUBLE: kind_ok = 1'b1;
      default:                kind_ok = 1'b0;
    endcase
  end

  assign tap_hit = enable_q && status_ok_i && status_byte_i[STATUS_TAP_BIT]
                   && tap_status_ok_i && kind_ok;

  always_comb begin
    item_o.do_sample = enable_q && sample_ok_i;
    item_o.x         = accel_x_i;
    item_o.y         = accel_y_i;
    item_o.z         = accel_z_i;
    item_o.tap_kind  = tap_hit ? tap_code : TAP_NONE;
    item_o.peak_read = peak_read_i;
    item_o.tap_poll  = tap_poll_i;
  end

endmodule
`default_nettype wire

// ===== sv/apt_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apt_fifo
// Short request queue between the classifier and the execution sequencer.
// ----------------------------------------------------------------------------
module apt_fifo import apt_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      item_i,
  input  wire logic  pop_i,
  output item_t      item_o,
  output q_status_t  status_o
);

  item_t            mem_q [Q_DEPTH];
  logic [PTR_W-1:0] wptr_q;
  logic [PTR_W-1:0] rptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push;
  logic             do_pop;

  assign status_o.full  = (count_q == CNT_W'(Q_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign item_o         = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(Q_DEPTH))
    else $error("request queue count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("request queue popped while empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("request queue lost a push");

endmodule
`default_nettype wire

// ===== sv/apt_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apt_isqrt
// Iterative integer square root, one root bit per cycle, with an exactness
// flag taken from the final remainder.
// ----------------------------------------------------------------------------
module apt_isqrt import apt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [RAD_W-1:0]  rad_i,
  output logic                   done_o,
  output logic [ROOT_W-1:0]      root_o,
  output logic                   exact_o
);

  logic                busy_q;
  logic                done_q;
  logic [STEP_W-1:0]   step_q;
  logic [RAD_W-1:0]    rad_q;
  logic [REM_W-1:0]    rem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [REM_W+1:0]    rem_sh;
  logic [REM_W+1:0]    trial;
  logic [REM_W+1:0]    diff;
  logic                fits;

  assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign fits   = (rem_sh >= trial);
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
        rad_q  <= rad_i;
        rem_q  <= '0;
        root_q <= '0;
      end else if (busy_q) begin
        rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
        rem_q  <= fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        root_q <= {root_q[ROOT_W-2:0], fits};
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o  = done_q;
  assign root_o  = root_q;
  assign exact_o = (rem_q == '0);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("square root started while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("square root done while still iterating");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("square root did not start");

endmodule
`default_nettype wire

// ===== sv/apt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apt_back
// Execution sequencer: sum of squares, scaling, square root, deviation,
// then peak and tap state update into the result register.
// ----------------------------------------------------------------------------
module apt_back import apt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  item_t            item_i,
  input  wire logic        q_empty_i,
  output logic             q_pop_o,
  input  wire logic        pop,
  output logic             empty,
  output logic [PEAK_W-1:0] peak_mg_o,
  output logic             tap_valid_o,
  output logic [KIND_W-1:0] tap_kind_o,
  output logic [SEQ_W-1:0] tap_seq_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SCALE,
    ST_ROOT,
    ST_EMIT
  } state_e;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  state_e             state_q;
  item_t              cur_q;
  logic [1:0]         axis_q;
  logic [SUM_W-1:0]   acc_q;
  logic [RAD_W-1:0]   rad_q;
  logic               sq_start_q;
  logic [PEAK_W-1:0]  dev_q;
  logic [PEAK_W-1:0]  peak_q;
  logic [KIND_W-1:0]  pend_q;
  logic [SEQ_W-1:0]   count_q;
  logic               out_valid_q;
  logic [PEAK_W-1:0]  out_peak_q;
  logic               out_tv_q;
  logic [KIND_W-1:0]  out_kind_q;
  logic [SEQ_W-1:0]   out_seq_q;

  logic signed [AXIS_W-1:0] axis_sel;
  logic signed [SQ_W-1:0]   sq;
  logic [RAD_W-1:0]         scaled;
  logic                     root_done;
  logic [ROOT_W-1:0]        root;
  logic                     exact;
  logic [ROOT_W-1:0]        hi_diff;
  logic [ROOT_W-1:0]        lo_diff;
  logic [ROOT_W-1:0]        dev_wide;
  logic [PEAK_W-1:0]        dev_sat;
  logic                     out_free;
  logic                     emit_go;
  logic [PEAK_W-1:0]        peak_upd;
  logic [KIND_W-1:0]        pend_upd;
  logic [SEQ_W-1:0]         count_upd;
  logic                     tap_hit;
  logic                     poll_hit;

  apt_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start_q),
    .rad_i   (rad_q),
    .done_o  (root_done),
    .root_o  (root),
    .exact_o (exact)
  );

  always_comb begin
    case (axis_q)
      AXIS_X:  axis_sel = cur_q.x;
      AXIS_Y:  axis_sel = cur_q.y;
      default: axis_sel = cur_q.z;
    endcase
  end

  assign sq     = axis_sel * axis_sel;
  assign scaled = RAD_W'(acc_q) * RAD_W'(RAD_SCALE);

  // Below 1 g the deviation uses the ceiling of the root.
  assign hi_diff  = root - REF_ROOT;
  assign lo_diff  = REF_ROOT - root - ROOT_W'(!exact);
  assign dev_wide = ((root >= REF_ROOT) ? hi_diff : lo_diff) >> LSB_SHIFT;
  assign dev_sat  = (dev_wide > ROOT_W'(PEAK_MAX)) ? PEAK_MAX : dev_wide[PEAK_W-1:0];

  assign out_free  = !out_valid_q || pop;
  assign emit_go   = (state_q == ST_EMIT) && out_free;
  assign peak_upd  = (cur_q.do_sample && (dev_q > peak_q)) ? dev_q : peak_q;
  assign tap_hit   = (cur_q.tap_kind != TAP_NONE);
  assign pend_upd  = tap_hit ? cur_q.tap_kind : pend_q;
  assign count_upd = tap_hit ? count_q + 1'b1 : count_q;
  assign poll_hit  = cur_q.tap_poll && (pend_upd != TAP_NONE);

  assign q_pop_o = (state_q == ST_IDLE) && !q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      axis_q      <= AXIS_X;
      acc_q       <= '0;
      rad_q       <= '0;
      sq_start_q  <= 1'b0;
      dev_q       <= '0;
      peak_q      <= '0;
      pend_q      <= TAP_NONE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_peak_q  <= '0;
      out_tv_q    <= 1'b0;
      out_kind_q  <= TAP_NONE;
      out_seq_q   <= '0;
    end else begin
      sq_start_q <= 1'b0;
      if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            cur_q   <= item_i;
            acc_q   <= '0;
            axis_q  <= AXIS_X;
            state_q <= item_i.do_sample ? ST_SQUARE : ST_EMIT;
          end
        end
        ST_SQUARE: begin
          acc_q  <= acc_q + SUM_W'(unsigned'(sq));
          axis_q <= axis_q + 1'b1;
          if (axis_q == AXIS_Z) begin
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          rad_q      <= scaled;
          sq_start_q <= 1'b1;
          state_q    <= ST_ROOT;
        end
        ST_ROOT: begin
          if (root_done) begin
            dev_q   <= dev_sat;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_peak_q  <= peak_upd;
            out_tv_q    <= poll_hit;
            out_kind_q  <= poll_hit ? pend_upd : TAP_NONE;
            out_seq_q   <= poll_hit ? count_upd : '0;
            peak_q      <= cur_q.peak_read ? '0 : peak_upd;
            pend_q      <= poll_hit ? TAP_NONE : pend_upd;
            count_q     <= count_upd;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign empty       = !out_valid_q;
  assign peak_mg_o   = out_peak_q;
  assign tap_valid_o = out_tv_q;
  assign tap_kind_o  = out_kind_q;
  assign tap_seq_o   = out_seq_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |=> out_valid_q)
    else $error("result lost at emit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop) |=> (out_valid_q && $stable(out_peak_q) && $stable(out_seq_q)))
    else $error("waiting result overwritten");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT && !root_done) |=> (state_q == ST_ROOT))
    else $error("left root wait early");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_tv_q |-> (out_kind_q == TAP_SINGLE || out_kind_q == TAP_DOUBLE))
    else $error("tap reported without a kind");

endmodule
`default_nettype wire
